[sv/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the escape-time counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int OPND_W    = 33;
  localparam int PROD_W    = 66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT  = 3'd0,
    CFG_SCALE  = 3'd1,
    CFG_OFF_RE = 3'd2,
    CFG_OFF_IM = 3'd3,
    CFG_W_RCP  = 3'd4,
    CFG_H_RCP  = 3'd5,
    CFG_ASPECT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] scale;
    logic signed [31:0] off_re;
    logic signed [31:0] off_im;
    logic        [31:0] w_rcp;
    logic        [31:0] h_rcp;
    logic        [30:0] aspect;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MAP_A,
    DP_MAP_B,
    DP_MAP_C,
    DP_MAP_D,
    DP_MAP_E,
    DP_MAP_F,
    DP_MUL,
    DP_UPD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_A,
    ST_MAP_B,
    ST_MAP_C,
    ST_MAP_D,
    ST_MAP_E,
    ST_MAP_F,
    ST_MUL,
    ST_UPD
  } state_t;

endpackage

[sv/mec_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mec_cfg_regs
// Configuration register file, one write beat per register.
// ----------------------------------------------------------------------------
module mec_cfg_regs import mec_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [31:0]           wr_data,
  output logic [COUNT_BITS-1:0] limit,
  output cfg_t                  cfg
);

  logic [COUNT_BITS-1:0] limit_r;
  cfg_t                  cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= COUNT_BITS'(256);
      cfg_r.scale   <= 32'sd805306368;
      cfg_r.off_re  <= '0;
      cfg_r.off_im  <= '0;
      cfg_r.w_rcp   <= 32'd4194304;
      cfg_r.h_rcp   <= 32'd4194304;
      cfg_r.aspect  <= 31'd268435456;
    end else if (wr_en) begin
      unique case (wr_idx)
        CFG_LIMIT:  limit_r      <= COUNT_BITS'(wr_data[15:0]);
        CFG_SCALE:  cfg_r.scale  <= wr_data;
        CFG_OFF_RE: cfg_r.off_re <= wr_data;
        CFG_OFF_IM: cfg_r.off_im <= wr_data;
        CFG_W_RCP:  cfg_r.w_rcp  <= wr_data;
        CFG_H_RCP:  cfg_r.h_rcp  <= wr_data;
        CFG_ASPECT: cfg_r.aspect <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  assign limit = limit_r;
  assign cfg   = cfg_r;

endmodule

[sv/mec_dp.sv]
// ----------------------------------------------------------------------------
// mec_dp
// Datapath: coordinate mapping and z = z*z + c iteration on three
// registered 33x33 multipliers.
// ----------------------------------------------------------------------------
module mec_dp import mec_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  cfg_t                  cfg,
  input  logic [COUNT_BITS-1:0] limit,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic                  in_last,
  output logic [COUNT_BITS-1:0] res_count,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y,
  output logic                  res_last
);

  localparam logic [31:0] HALF = 32'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] FOUR = PROD_W'(1) << (2 * FRAC_BITS + 2);

  function automatic logic [30:0] sat31(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:31]) ? 31'h7FFF_FFFF : v[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic all0;
    logic all1;
    all0 = ~|v[PROD_W-1:31];
    all1 = &v[PROD_W-1:31];
    if (all0 || all1) return v[31:0];
    return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [PROD_W-1:0] ext32(input logic signed [31:0] v);
    return {{(PROD_W-32){v[31]}}, v};
  endfunction

  logic [COORD_BITS-1:0] px_r, py_r;
  logic                  last_r;
  logic [30:0]           ax_r, ay_r;
  logic signed [31:0]    cx_r, cy_r, zx_r, zy_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  chk_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;

  logic signed [OPND_W-1:0] a0, b0, a1, b1, a2, b2;
  logic [31:0]              dx, dy;

  logic signed [PROD_W-1:0] diff, mag, nx, ny;
  logic                     ovf, pass;
  logic [COUNT_BITS-1:0]    cnt_nxt;

  assign dx = {1'b0, ax_r} - HALF;
  assign dy = {1'b0, ay_r} - HALF;

  always_comb begin
    a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0;
    unique case (cmd.op)
      DP_MAP_A: begin
        a0 = {{(OPND_W-COORD_BITS){1'b0}}, px_r};
        b0 = {1'b0, cfg.w_rcp};
        a1 = {{(OPND_W-COORD_BITS){1'b0}}, py_r};
        b1 = {1'b0, cfg.h_rcp};
      end
      DP_MAP_C: begin
        a0 = {2'b00, ax_r};
        b0 = {2'b00, cfg.aspect};
        a1 = {dy[31], dy};
        b1 = {cfg.scale[31], cfg.scale};
      end
      DP_MAP_E: begin
        a0 = {dx[31], dx};
        b0 = {cfg.scale[31], cfg.scale};
      end
      DP_MUL: begin
        a0 = {zx_r[31], zx_r};
        b0 = {zx_r[31], zx_r};
        a1 = {zy_r[31], zy_r};
        b1 = {zy_r[31], zy_r};
        a2 = {zx_r[31], zx_r};
        b2 = {zy_r[31], zy_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p0_r <= a0 * b0;
    p1_r <= a1 * b1;
    p2_r <= a2 * b2;
  end

  always_comb begin
    diff    = p0_r - p1_r;
    mag     = p0_r + p1_r;
    nx      = (diff >>> FRAC_BITS) + ext32(cx_r);
    ny      = (p2_r >>> (FRAC_BITS - 1)) + ext32(cy_r);
    ovf     = !((&nx[PROD_W-1:31]) || !(|nx[PROD_W-1:31])) ||
              !((&ny[PROD_W-1:31]) || !(|ny[PROD_W-1:31]));
    pass    = !chk_r || (mag < FOUR);
    cnt_nxt = chk_r ? count_r + COUNT_BITS'(1) : count_r;
    stat.stop = (cmd.op == DP_UPD) && (!pass || (cnt_nxt == limit) || ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        DP_LOAD: begin
          px_r   <= in_x;
          py_r   <= in_y;
          last_r <= in_last;
        end
        DP_MAP_B: begin
          ax_r <= sat31(p0_r >> (32 - FRAC_BITS));
          ay_r <= sat31(p1_r >> (32 - FRAC_BITS));
        end
        DP_MAP_D: begin
          ax_r <= sat31(p0_r >> FRAC_BITS);
          cy_r <= sat32((p1_r >>> FRAC_BITS) + ext32(cfg.off_im));
        end
        DP_MAP_F: begin
          cx_r    <= sat32((p0_r >>> FRAC_BITS) + ext32(cfg.off_re));
          zx_r    <= sat32((p0_r >>> FRAC_BITS) + ext32(cfg.off_re));
          zy_r    <= cy_r;
          count_r <= '0;
          chk_r   <= 1'b0;
        end
        DP_UPD: begin
          if (pass) begin
            count_r <= cnt_nxt;
            if (!stat.stop) begin
              zx_r  <= nx[31:0];
              zy_r  <= ny[31:0];
              chk_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_count = (count_r == limit) ? '0 : count_r;
  assign res_x     = px_r;
  assign res_y     = py_r;
  assign res_last  = last_r;

endmodule

[sv/mec_ctrl.sv]
// ----------------------------------------------------------------------------
// mec_ctrl
// Controller: sequences the mapping steps and the multiply/update loop.
// ----------------------------------------------------------------------------
module mec_ctrl import mec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd.op    = DP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_MAP_A;
        end
      end
      ST_MAP_A: begin cmd.op = DP_MAP_A; state_nxt = ST_MAP_B; end
      ST_MAP_B: begin cmd.op = DP_MAP_B; state_nxt = ST_MAP_C; end
      ST_MAP_C: begin cmd.op = DP_MAP_C; state_nxt = ST_MAP_D; end
      ST_MAP_D: begin cmd.op = DP_MAP_D; state_nxt = ST_MAP_E; end
      ST_MAP_E: begin cmd.op = DP_MAP_E; state_nxt = ST_MAP_F; end
      ST_MAP_F: begin cmd.op = DP_MAP_F; state_nxt = ST_MUL;   end
      ST_MUL:   begin cmd.op = DP_MUL;   state_nxt = ST_UPD;   end
      ST_UPD: begin
        cmd.op = DP_UPD;
        if (stat.stop) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign done = done_r;

endmodule

[sv/mandelbrot_escape_counter_top.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_top
// Escape-time counter: one pixel in, one iteration count out.
//
//  channel | ports                                   | beat when
//  --------+-----------------------------------------+----------------------
//  input   | in_pixel_x, in_pixel_y, in_last_in_block | start && !busy
//  result  | out_escape_count, out_pixel_x/_y, _end  | out_valid
//  config  | cfg_index, cfg_data                     | cfg_valid && cfg_ready
//
//  Pixels are taken one at a time: a new pixel is accepted only once busy
//  has dropped, after the mapping steps and the multiply/update loop on the
//  three shared multipliers have run for the last one.
//  out_valid is high for one cycle, the cycle busy drops; results cannot
//  be stalled. cfg_ready is always high. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter_top import mec_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic                  in_last_in_block,
  output logic                  out_valid,
  output logic [COUNT_BITS-1:0] out_escape_count,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_block_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  logic [COUNT_BITS-1:0] limit;
  cfg_t                  cfg;
  dp_cmd_t               cmd;
  dp_stat_t              stat;

  assign cfg_ready = 1'b1;

  mec_cfg_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cfg_valid && cfg_ready),
    .wr_idx (cfg_index),
    .wr_data(cfg_data),
    .limit  (limit),
    .cfg    (cfg)
  );

  mec_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (out_valid),
    .cmd  (cmd),
    .stat (stat)
  );

  mec_dp #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg),
    .limit    (limit),
    .in_x     (in_pixel_x),
    .in_y     (in_pixel_y),
    .in_last  (in_last_in_block),
    .res_count(out_escape_count),
    .res_x    (out_pixel_x),
    .res_y    (out_pixel_y),
    .res_last (out_block_end)
  );

endmodule
